// ===== rtl/sird_pkg.sv =====
// Shared types and constants for the signed integer to radix digits block.
package sird_pkg;

  localparam int MAX_BASE_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Input value and configuration widths are fixed by the interface.
  localparam int VALUE_PORT_W = 32;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int COUNT_W      = 5;
  localparam int NUM_SYMBOLS  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_COUNT = 2'd2;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic chk_step;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic chk_bad;
    logic chk_last;
    logic div_last;
    logic q_zero;
    logic neg;
    logic last_digit;
  } stat_t;

endpackage

// ===== rtl/sird_dp.sv =====
// Datapath: alphabet registers, alphabet check, chunked divider, digit stack, output register.
module sird_dp #(
  parameter int MAX_BASE    = sird_pkg::MAX_BASE_DEF,
  parameter int VALUE_WIDTH = sird_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [sird_pkg::CFG_INDEX_W-1:0]      wr_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]       wr_data,
  input  logic signed [sird_pkg::VALUE_PORT_W-1:0] value,
  input  sird_pkg::cmd_t                        cmd,
  output sird_pkg::stat_t                       stat,
  output logic [7:0]                            out_char,
  output logic                                  is_last,
  output logic                                  strobe
);

  localparam int DIGW   = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;  // digit / check index width
  localparam int BPC    = 4;                                      // quotient bits per cycle
  localparam int CHUNKS = (VALUE_WIDTH + BPC - 1) / BPC;
  localparam int DW     = CHUNKS * BPC;
  localparam int CCW    = $clog2(CHUNKS);
  localparam int SPW    = $clog2(VALUE_WIDTH + 1);
  localparam int SIW    = $clog2(VALUE_WIDTH);

  // Configuration registers
  logic [sird_pkg::CFG_DATA_W-1:0] symbols_low;
  logic [sird_pkg::CFG_DATA_W-1:0] symbols_high;
  logic [sird_pkg::COUNT_W-1:0]    symbol_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
      symbol_count <= '0;
    end else if (wr_en) begin
      case (wr_index)
        sird_pkg::REG_SYMBOLS_LOW:  symbols_low  <= wr_data;
        sird_pkg::REG_SYMBOLS_HIGH: symbols_high <= wr_data;
        sird_pkg::REG_SYMBOL_COUNT: symbol_count <= wr_data[sird_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [7:0] sym [sird_pkg::NUM_SYMBOLS];
  always_comb begin
    for (int j = 0; j < sird_pkg::NUM_SYMBOLS; j++) begin
      if (j < 8) sym[j] = symbols_low[8*j +: 8];
      else       sym[j] = symbols_high[8*(j-8) +: 8];
    end
  end

  // Alphabet check, one symbol per cycle against all later symbols in use
  logic [DIGW-1:0] chk_idx;
  logic [3:0]      chk_sel;
  logic [7:0]      chk_sym;
  logic            chk_dup;
  logic            range_bad;

  assign chk_sel   = 4'(chk_idx);
  assign chk_sym   = sym[chk_sel];
  assign range_bad = (symbol_count < 5'd2) || (symbol_count > 5'(MAX_BASE));

  always_comb begin
    chk_dup = 1'b0;
    for (int j = 0; j < sird_pkg::NUM_SYMBOLS; j++) begin
      if ((5'(j) > 5'(chk_idx)) && (5'(j) < symbol_count) && (sym[j] == chk_sym))
        chk_dup = 1'b1;
    end
  end

  assign stat.chk_bad  = range_bad || chk_dup || (chk_sym == sird_pkg::CHAR_NUL) ||
                         (chk_sym == sird_pkg::CHAR_PLUS) || (chk_sym == sird_pkg::CHAR_MINUS);
  assign stat.chk_last = (5'(chk_idx) == (symbol_count - 5'd1));

  // Divider: working register holds remaining dividend high, quotient shifted in low
  logic [DW-1:0]   wrk, wrk_next;
  logic [DIGW-1:0] rem, rem_next;
  logic [CCW-1:0]  chunk;
  logic [DIGW:0]   rad;
  logic            neg;
  logic [VALUE_WIDTH-1:0] raw, mag;

  assign rad = symbol_count[DIGW:0];
  assign raw = value[VALUE_WIDTH-1:0];
  assign mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    logic [DIGW:0] t;
    wrk_next = wrk;
    rem_next = rem;
    for (int k = 0; k < BPC; k++) begin
      t = {rem_next, wrk_next[DW-1]};
      wrk_next = {wrk_next[DW-2:0], 1'b0};
      if (t >= rad) begin
        t = t - rad;
        wrk_next[0] = 1'b1;
      end
      rem_next = t[DIGW-1:0];
    end
  end

  assign stat.div_last = (chunk == CCW'(CHUNKS - 1));
  assign stat.q_zero   = (wrk_next == '0);
  assign stat.neg      = neg;

  // Digit stack, least significant digit pushed first
  logic [DIGW-1:0] stack [VALUE_WIDTH];
  logic [SPW-1:0]  sp;
  logic [SPW-1:0]  sp_dec;
  logic [DIGW-1:0] top_digit;

  assign sp_dec          = sp - 1'b1;
  assign top_digit       = stack[sp_dec[SIW-1:0]];
  assign stat.last_digit = (sp == SPW'(1));

  always_ff @(posedge clk) begin
    if (cmd.div_step && stat.div_last) stack[sp[SIW-1:0]] <= rem_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_idx <= '0;
      chunk   <= '0;
      sp      <= '0;
    end else if (cmd.load) begin
      chk_idx <= '0;
      chunk   <= '0;
      sp      <= '0;
    end else begin
      if (cmd.chk_step) chk_idx <= chk_idx + 1'b1;
      if (cmd.div_step) chunk <= stat.div_last ? '0 : chunk + 1'b1;
      if (cmd.div_step && stat.div_last) sp <= sp + 1'b1;
      else if (cmd.emit_digit) sp <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wrk <= DW'(mag);
      rem <= '0;
      neg <= raw[VALUE_WIDTH-1];
    end else if (cmd.div_step) begin
      wrk <= wrk_next;
      rem <= stat.div_last ? '0 : rem_next;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= cmd.emit_sign || cmd.emit_digit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= sird_pkg::CHAR_MINUS;
      is_last  <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= sym[4'(top_digit)];
      is_last  <= stat.last_digit;
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(VALUE_WIDTH)) else $error("digit stack overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> (sp != '0)) else $error("pop from empty digit stack");
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_last) |=> !strobe) else $error("beat right after last beat");

endmodule

// ===== rtl/sird_ctrl.sv =====
// Controller: sequences alphabet check, digit division and character emission.
module sird_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sird_pkg::stat_t stat,
  output sird_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.chk_bad)       state_next = S_IDLE;
        else if (stat.chk_last) state_next = S_DIV;
        else                    cmd.chk_step = 1'b1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last && stat.q_zero) state_next = stat.neg ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (stat.last_digit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_sign_then_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIGN) |=> (state == S_EMIT)) else $error("sign not followed by digits");
  a_bad_abort: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && stat.chk_bad) |=> (state == S_IDLE)) else $error("bad alphabet not dropped");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.div_last && stat.q_zero) |=> (state == S_SIGN || state == S_EMIT))
    else $error("division end not followed by emission");

endmodule

// ===== rtl/signed_integer_to_radix_digits.sv =====
// Top level: signed integer to text in a configurable radix, most significant digit first.
//
// A value is taken when start is high and busy is low; the text comes out one character
// per beat on out_char, marked by strobe for a single cycle, with is_last on the final
// character. The receiver cannot stall, so every beat must be taken when shown. For
// each value: the value is loaded, then the alphabet check steps through the symbols in use
// (stops early on a bad symbol or symbol count, in which case nothing is emitted and busy
// drops), then each digit takes one pass of the shared divider over all chunks of the dividend,
// which retires four quotient bits a cycle, then the characters (sign, then digits) go out
// back to back. The divider loop dominates the time per value. The last beat is shown in the
// first cycle with busy low, so the next value can be taken while it is on the ports.
// Configuration writes are only legal while idle.
module signed_integer_to_radix_digits #(
  parameter int MAX_BASE    = sird_pkg::MAX_BASE_DEF,
  parameter int VALUE_WIDTH = sird_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [sird_pkg::VALUE_PORT_W-1:0] value,
  input  logic                                     wr_en,
  input  logic [sird_pkg::CFG_INDEX_W-1:0]         wr_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]          wr_data,
  output logic                                     strobe,
  output logic [7:0]                               out_char,
  output logic                                     is_last
);

  sird_pkg::cmd_t  cmd;
  sird_pkg::stat_t stat;

  // Sequencer
  sird_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Registers, check logic, divider, digit stack and output beat
  sird_dp #(
    .MAX_BASE    (MAX_BASE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .value    (value),
    .cmd      (cmd),
    .stat     (stat),
    .out_char (out_char),
    .is_last  (is_last),
    .strobe   (strobe)
  );

endmodule
